// File: sv/stt_pkg.sv
// Shared types, constants and helper functions of the scene text tokenizer.
`default_nettype none

package stt_pkg;

    // Counter widths and result field widths
    localparam int LINE_BITS   = 20;
    localparam int COL_BITS    = 16;
    localparam int LINE_W      = 20;
    localparam int COL_W       = 16;
    localparam int LEN_W       = 16;
    localparam int MAX_RES     = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Byte codes
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [3:0] {
        MODE_BLANK,
        MODE_AFTER_CR,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_ESCAPE,
        MODE_ERROR
    } t_mode;

    typedef enum logic [2:0] {
        CLS_SYMBOL,
        CLS_IDENT,
        CLS_NUMBER,
        CLS_STRING,
        CLS_EOF,
        CLS_ERROR
    } t_class;

    typedef enum logic [1:0] {
        FAULT_NONE,
        FAULT_SLASH,
        FAULT_UNTERM,
        FAULT_INVALID
    } t_fault;

    typedef struct packed {
        t_class              cls;
        logic [7:0]          lead;
        logic [LINE_W-1:0]   line;
        logic [COL_W-1:0]    col;
        logic [LEN_W-1:0]    len;
        t_fault              fault;
        logic                last;
    } t_result;

    // Results caused by one accepted byte, slot 0 first
    typedef struct packed {
        logic [1:0]                n;
        t_result [MAX_RES-1:0]     res;
    } t_batch;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return c == CH_LBRACE || c == CH_RBRACE || c == CH_COLON ||
               c == CH_COMMA || c == CH_AT;
    endfunction

    function automatic logic ident_more(input logic [7:0] c);
        return c == CH_UNDER || is_letter(c) || is_digit(c);
    endfunction

    function automatic logic number_more(input logic [7:0] c);
        return c == CH_DOT || is_digit(c);
    endfunction

    function automatic t_result mk_res(
        input t_class               cls,
        input logic [7:0]           lead,
        input logic [LINE_BITS-1:0] line,
        input logic [COL_BITS-1:0]  col,
        input logic [LEN_W-1:0]     len,
        input t_fault               fault
    );
        t_result r;
        r.cls   = cls;
        r.lead  = lead;
        r.line  = LINE_W'(line);
        r.col   = COL_W'(col);
        r.len   = len;
        r.fault = fault;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/stt_in_if.sv
// Byte request channel of the tokenizer.
`default_nettype none

interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_text;

    modport source (output valid, output char_byte, output end_of_text, input ready);
    modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// File: sv/stt_out_if.sv
// Token request channel of the tokenizer.
`default_nettype none

interface stt_out_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                token_class;
    logic [7:0]                lead_byte;
    logic [stt_pkg::LINE_W-1:0] start_line;
    logic [stt_pkg::COL_W-1:0] start_column;
    logic [stt_pkg::LEN_W-1:0] token_length;
    logic [1:0]                fault_code;
    logic                      run_last;

    modport source (output valid, output token_class, output lead_byte, output start_line,
                    output start_column, output token_length, output fault_code,
                    output run_last, input ready);
    modport sink   (input valid, input token_class, input lead_byte, input start_line,
                    input start_column, input token_length, input fault_code,
                    input run_last, output ready);
endinterface

`default_nettype wire

// File: sv/stt_scan.sv
// Scanner: mode and position registers plus the one-byte step logic.
`default_nettype none

module stt_scan (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_char,
    input  wire logic          i_last,
    output stt_pkg::t_batch    o_batch
);
    import stt_pkg::*;

    t_mode                r_mode, n_mode;
    logic [LINE_BITS-1:0] r_line, n_line, r_tok_line, n_tok_line;
    logic [COL_BITS-1:0]  r_col, n_col, r_tok_col, n_tok_col;
    logic [LEN_W-1:0]     r_tok_len, n_tok_len;
    logic [7:0]           r_tok_first, n_tok_first;

    function automatic logic [COL_BITS-1:0] col_sat(input logic [COL_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [LINE_BITS-1:0] line_sat(input logic [LINE_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [LEN_W-1:0] len_sat(input logic [LEN_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // next state and results of one byte
    always_comb begin
        t_mode                m;
        logic [LINE_BITS-1:0] ln, tl;
        logic [COL_BITS-1:0]  cl, tc;
        logic [LEN_W-1:0]     tlen;
        logic [7:0]           tf;
        logic [1:0]           n;
        logic                 do_start;
        t_result [MAX_RES-1:0] res;

        m        = r_mode;
        ln       = r_line;
        cl       = r_col;
        tl       = r_tok_line;
        tc       = r_tok_col;
        tlen     = r_tok_len;
        tf       = r_tok_first;
        n        = 2'd0;
        do_start = 1'b0;
        res      = '0;

        unique case (r_mode) inside
            MODE_BLANK: begin
                do_start = 1'b1;
            end
            MODE_AFTER_CR: begin
                if (i_char == CH_LF) begin
                    m = MODE_BLANK;
                end else begin
                    do_start = 1'b1;
                end
            end
            MODE_SLASH: begin
                if (i_char == CH_SLASH) begin
                    cl = col_sat(cl);
                    m  = MODE_COMMENT;
                end else begin
                    res[n] = mk_res(CLS_ERROR, CH_SLASH, tl, tc, LEN_W'(1), FAULT_SLASH);
                    n      = n + 2'd1;
                    m      = MODE_ERROR;
                end
            end
            MODE_COMMENT: begin
                if (i_char == CH_CR) begin
                    ln = line_sat(ln);
                    cl = '0;
                    m  = MODE_AFTER_CR;
                end else if (i_char == CH_LF) begin
                    ln = line_sat(ln);
                    cl = '0;
                    m  = MODE_BLANK;
                end else begin
                    cl = col_sat(cl);
                end
            end
            MODE_IDENT, MODE_NUMBER: begin
                if (r_mode == MODE_IDENT ? ident_more(i_char) : number_more(i_char)) begin
                    tlen = len_sat(tlen);
                    cl   = col_sat(cl);
                end else begin
                    res[n]   = mk_res(r_mode == MODE_IDENT ? CLS_IDENT : CLS_NUMBER,
                                      tf, tl, tc, tlen, FAULT_NONE);
                    n        = n + 2'd1;
                    do_start = 1'b1;
                end
            end
            MODE_STRING: begin
                if (i_char == CH_CR || i_char == CH_LF) begin
                    res[n] = mk_res(CLS_ERROR, tf, tl, tc, tlen, FAULT_UNTERM);
                    n      = n + 2'd1;
                    m      = MODE_ERROR;
                end else begin
                    tlen = len_sat(tlen);
                    cl   = col_sat(cl);
                    if (i_char == CH_BSLASH) begin
                        m = MODE_ESCAPE;
                    end else if (i_char == CH_QUOTE) begin
                        res[n] = mk_res(CLS_STRING, tf, tl, tc, tlen, FAULT_NONE);
                        n      = n + 2'd1;
                        m      = MODE_BLANK;
                    end
                end
            end
            MODE_ESCAPE: begin
                tlen = len_sat(tlen);
                cl   = col_sat(cl);
                m    = MODE_STRING;
            end
            default: begin
                m = MODE_ERROR;
            end
        endcase

        // a byte that opens something new, also the one that ended a word
        if (do_start) begin
            m = MODE_BLANK;
            if (i_char == CH_CR) begin
                ln = line_sat(ln);
                cl = '0;
                m  = MODE_AFTER_CR;
            end else if (i_char == CH_LF) begin
                ln = line_sat(ln);
                cl = '0;
            end else if (i_char == CH_SPACE || i_char == CH_TAB) begin
                cl = col_sat(cl);
            end else if (i_char == CH_SLASH || is_symbol(i_char) || i_char == CH_UNDER ||
                         i_char == CH_DOLLAR || is_letter(i_char) || i_char == CH_PLUS ||
                         i_char == CH_MINUS || i_char == CH_DOT || is_digit(i_char) ||
                         i_char == CH_QUOTE) begin
                tl   = ln;
                tc   = cl;
                tlen = LEN_W'(1);
                tf   = i_char;
                cl   = col_sat(cl);
                if (i_char == CH_SLASH) begin
                    m = MODE_SLASH;
                end else if (is_symbol(i_char)) begin
                    res[n] = mk_res(CLS_SYMBOL, i_char, tl, tc, LEN_W'(1), FAULT_NONE);
                    n      = n + 2'd1;
                end else if (i_char == CH_UNDER || i_char == CH_DOLLAR ||
                             is_letter(i_char)) begin
                    m = MODE_IDENT;
                end else if (i_char == CH_QUOTE) begin
                    m = MODE_STRING;
                end else begin
                    m = MODE_NUMBER;
                end
            end else begin
                res[n] = mk_res(CLS_ERROR, i_char, ln, cl, LEN_W'(1), FAULT_INVALID);
                n      = n + 2'd1;
                m      = MODE_ERROR;
            end
        end

        // end of file: flush pending token, then the end marker, then reset
        if (i_last) begin
            if (m == MODE_IDENT || m == MODE_NUMBER) begin
                res[n] = mk_res(m == MODE_IDENT ? CLS_IDENT : CLS_NUMBER,
                                tf, tl, tc, tlen, FAULT_NONE);
                n      = n + 2'd1;
            end else if (m == MODE_STRING || m == MODE_ESCAPE) begin
                res[n] = mk_res(CLS_ERROR, tf, tl, tc, tlen, FAULT_UNTERM);
                n      = n + 2'd1;
            end else if (m == MODE_SLASH) begin
                res[n] = mk_res(CLS_ERROR, CH_SLASH, tl, tc, LEN_W'(1), FAULT_SLASH);
                n      = n + 2'd1;
            end
            res[n] = mk_res(CLS_EOF, CH_NUL, ln, cl, '0, FAULT_NONE);
            n      = n + 2'd1;
            m      = MODE_BLANK;
            ln     = '0;
            cl     = '0;
            tl     = '0;
            tc     = '0;
            tlen   = '0;
            tf     = '0;
        end

        if (n != 2'd0) begin
            res[n - 2'd1].last = 1'b1;
        end

        n_mode      = m;
        n_line      = ln;
        n_col       = cl;
        n_tok_line  = tl;
        n_tok_col   = tc;
        n_tok_len   = tlen;
        n_tok_first = tf;
        o_batch.n   = n;
        o_batch.res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_BLANK;
            r_line      <= '0;
            r_col       <= '0;
            r_tok_line  <= '0;
            r_tok_col   <= '0;
            r_tok_len   <= '0;
            r_tok_first <= '0;
        end else if (i_accept) begin
            r_mode      <= n_mode;
            r_line      <= n_line;
            r_col       <= n_col;
            r_tok_line  <= n_tok_line;
            r_tok_col   <= n_tok_col;
            r_tok_len   <= n_tok_len;
            r_tok_first <= n_tok_first;
        end
    end

`ifndef SYNTHESIS
    a_eof_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last |=> r_mode == MODE_BLANK && r_line == '0 && r_col == '0)
        else $error("scanner not back to reset after end of file");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_last && r_mode == MODE_ERROR |=>
            r_mode == MODE_ERROR && $stable(r_line) && $stable(r_col))
        else $error("error mode left or position moved before end of file");
`endif

endmodule

`default_nettype wire

// File: sv/stt_resq.sv
// Result queue: takes up to three results a cycle, hands out one a cycle.
`default_nettype none

module stt_resq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire stt_pkg::t_batch i_push,
    input  wire logic          i_pop,
    output stt_pkg::t_result   o_head,
    output logic               o_nonempty,
    output logic               o_room
);
    import stt_pkg::*;

    t_result            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_rd, r_wr;
    logic [CNT_W-1:0]   r_cnt;
    logic               pop_ok;

    assign o_nonempty = r_cnt != '0;
    assign o_room     = r_cnt <= CNT_W'(QUEUE_DEPTH - MAX_RES);
    assign o_head     = r_mem[r_rd];
    assign pop_ok     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (k < int'(i_push.n)) begin
                r_mem[r_wr + PTR_W'(k)] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PTR_W'(i_push.n);
            r_rd  <= r_rd + PTR_W'(pop_ok);
            r_cnt <= r_cnt + CNT_W'(i_push.n) - CNT_W'(pop_ok);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.n != 2'd0 |-> o_room)
        else $error("results pushed without room");
`endif

endmodule

`default_nettype wire

// File: sv/scene_text_tokenizer_unit.sv
// Top level of the scene text tokenizer: scanner plus result queue.
// Tokens of an accepted byte are written to the result queue; the output shows the queue head.
// Throughput: one byte per cycle while each byte yields at most one token and the receiver
//   takes each token; a byte with more tokens (up to three) keeps the output busy until done.
// The four-entry result queue sets the input stall: bytes are taken while it holds one or none.
// Reset (synchronous, active low) clears mode, line, column and the queue.
`default_nettype none

module scene_text_tokenizer_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stt_in_if.sink     i_in,
    stt_out_if.source  o_out
);
    import stt_pkg::*;

    logic     accept;
    logic     room;
    logic     nonempty;
    t_batch   scan_batch;
    t_batch   push_batch;
    t_result  head;

    // a request is taken whenever the queue can absorb its worst case of three tokens
    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    stt_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_in.char_byte),
        .i_last   (i_in.end_of_text),
        .o_batch  (scan_batch)
    );

    // only an accepted byte pushes its tokens
    always_comb begin
        push_batch = scan_batch;
        if (!accept) begin
            push_batch.n = 2'd0;
        end
    end

    stt_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push_batch),
        .i_pop      (o_out.ready),
        .o_head     (head),
        .o_nonempty (nonempty),
        .o_room     (room)
    );

    // output request straight from the queue head
    assign o_out.valid        = nonempty;
    assign o_out.token_class  = head.cls;
    assign o_out.lead_byte    = head.lead;
    assign o_out.start_line   = head.line;
    assign o_out.start_column = head.col;
    assign o_out.token_length = head.len;
    assign o_out.fault_code   = head.fault;
    assign o_out.run_last     = head.last;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the scene text tokenizer: byte files driven in, tokens checked against an inline scanner.

module tb_top;
    import stt_pkg::*;

    // Longest random wait on either side, in cycles
    localparam int STALL_MAX    = 14;
    // Cycles with no request moving on either channel before the run is abandoned.
    // A slow but correct run idles at most one sender gap plus three receiver stalls.
    localparam int IDLE_LIMIT   = 1000;
    // Settling time after the last token
    localparam int DRAIN_CYCLES = 16;
    // Rough size of the random part
    localparam int RANDOM_BYTES = 140;
    // Mismatch lines printed before going quiet (all are still counted)
    localparam int PRINT_CAP    = 60;

    // One pending byte request; 'steady' means no idle cycles after it
    typedef struct {
        logic [7:0] ch;
        logic       eot;
        bit         steady;
    } t_src_byte;

    logic clk;
    logic rst_n;

    stt_in_if  byte_ch ();
    stt_out_if token_ch ();

    scene_text_tokenizer_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (token_ch)
    );

    // ------------------------------------------------------------------
    // Stimulus store and scanner state
    // ------------------------------------------------------------------
    t_src_byte         pending_bytes[$];
    logic [7:0]        file_buf[$];
    t_result           expected_tokens[$];

    t_mode             scan_mode;
    logic [LINE_W-1:0] cur_line;
    logic [COL_W-1:0]  cur_col;
    logic [LINE_W-1:0] tok_line;
    logic [COL_W-1:0]  tok_col;
    logic [LEN_W-1:0]  tok_len;
    logic [7:0]        tok_lead;

    int total_bytes   = 0;
    int bytes_taken   = 0;   // written by the monitor only
    int bytes_seen    = 0;   // written by the byte driver only
    int tokens_taken  = 0;   // written by the monitor only
    int tokens_seen   = 0;   // written by the token receiver only
    int error_count   = 0;
    int idle_cycles   = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int steady_tokens = 0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic note_error(string msg);
        error_count++;
        if (error_count <= PRINT_CAP) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            note_error($sformatf("token %0d %s = %0h, expected %0h", tokens_taken, name, got, want));
        end
    endtask

    // ------------------------------------------------------------------
    // Scanner prediction
    // ------------------------------------------------------------------
    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_dec(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Back to the state held after reset; also done after every end of file
    task automatic clear_scan();
        scan_mode = MODE_BLANK;
        cur_line  = '0;
        cur_col   = '0;
        tok_line  = '0;
        tok_col   = '0;
        tok_len   = '0;
        tok_lead  = '0;
    endtask

    task automatic emit(t_class cls, logic [7:0] lead, logic [LINE_W-1:0] ln,
                        logic [COL_W-1:0] cl, logic [LEN_W-1:0] len, t_fault fault);
        t_result r;
        r.cls   = cls;
        r.lead  = lead;
        r.line  = ln;
        r.col   = cl;
        r.len   = len;
        r.fault = fault;
        r.last  = 1'b0;
        expected_tokens.push_back(r);
    endtask

    // Column and line counters stick at all ones
    task automatic bump_col();
        if (cur_col != {COL_W{1'b1}}) cur_col++;
    endtask

    task automatic line_break();
        if (cur_line != {LINE_W{1'b1}}) cur_line++;
        cur_col = '0;
    endtask

    task automatic extend_token();
        if (tok_len != {LEN_W{1'b1}}) tok_len++;
        bump_col();
    endtask

    task automatic open_token(logic [7:0] c, t_mode m);
        tok_line  = cur_line;
        tok_col   = cur_col;
        tok_len   = LEN_W'(1);
        tok_lead  = c;
        bump_col();
        scan_mode = m;
    endtask

    // Pending ident or number flushed as a token
    task automatic emit_word();
        if (scan_mode == MODE_IDENT) begin
            emit(CLS_IDENT, tok_lead, tok_line, tok_col, tok_len, FAULT_NONE);
        end else begin
            emit(CLS_NUMBER, tok_lead, tok_line, tok_col, tok_len, FAULT_NONE);
        end
    endtask

    // A byte seen where a new token may begin
    task automatic scan_start(logic [7:0] c);
        scan_mode = MODE_BLANK;
        if (c == CH_CR) begin
            line_break();
            scan_mode = MODE_AFTER_CR;
        end else if (c == CH_LF) begin
            line_break();
        end else if (c == CH_SPACE || c == CH_TAB) begin
            bump_col();
        end else if (c == CH_SLASH) begin
            open_token(c, MODE_SLASH);
        end else if (c inside {CH_LBRACE, CH_RBRACE, CH_COLON, CH_COMMA, CH_AT}) begin
            open_token(c, MODE_BLANK);
            emit(CLS_SYMBOL, c, tok_line, tok_col, LEN_W'(1), FAULT_NONE);
        end else if (c == CH_UNDER || c == CH_DOLLAR || is_alpha(c)) begin
            open_token(c, MODE_IDENT);
        end else if (c == CH_PLUS || c == CH_MINUS || c == CH_DOT || is_dec(c)) begin
            open_token(c, MODE_NUMBER);
        end else if (c == CH_QUOTE) begin
            open_token(c, MODE_STRING);
        end else begin
            emit(CLS_ERROR, c, cur_line, cur_col, LEN_W'(1), FAULT_INVALID);
            scan_mode = MODE_ERROR;
        end
    endtask

    // Works out every token that one accepted byte gives rise to
    task automatic tokenize_byte(logic [7:0] c, logic eot);
        int  base_count;
        bit  goes_on;
        base_count = expected_tokens.size();
        case (scan_mode) inside
            MODE_BLANK: begin
                scan_start(c);
            end
            MODE_AFTER_CR: begin
                // LF straight after CR belongs to the same line end
                if (c == CH_LF) scan_mode = MODE_BLANK;
                else scan_start(c);
            end
            MODE_SLASH: begin
                if (c == CH_SLASH) begin
                    bump_col();
                    scan_mode = MODE_COMMENT;
                end else begin
                    emit(CLS_ERROR, CH_SLASH, tok_line, tok_col, LEN_W'(1), FAULT_SLASH);
                    scan_mode = MODE_ERROR;
                end
            end
            MODE_COMMENT: begin
                if (c == CH_CR) begin
                    line_break();
                    scan_mode = MODE_AFTER_CR;
                end else if (c == CH_LF) begin
                    line_break();
                    scan_mode = MODE_BLANK;
                end else begin
                    bump_col();
                end
            end
            MODE_IDENT, MODE_NUMBER: begin
                if (scan_mode == MODE_IDENT) goes_on = c == CH_UNDER || is_alpha(c) || is_dec(c);
                else goes_on = c == CH_DOT || is_dec(c);
                if (goes_on) begin
                    extend_token();
                end else begin
                    // the ending byte is rescanned as a fresh start in the same step
                    emit_word();
                    scan_start(c);
                end
            end
            MODE_STRING: begin
                if (c == CH_CR || c == CH_LF) begin
                    emit(CLS_ERROR, tok_lead, tok_line, tok_col, tok_len, FAULT_UNTERM);
                    scan_mode = MODE_ERROR;
                end else begin
                    extend_token();
                    if (c == CH_BSLASH) begin
                        scan_mode = MODE_ESCAPE;
                    end else if (c == CH_QUOTE) begin
                        emit(CLS_STRING, tok_lead, tok_line, tok_col, tok_len, FAULT_NONE);
                        scan_mode = MODE_BLANK;
                    end
                end
            end
            MODE_ESCAPE: begin
                extend_token();
                scan_mode = MODE_STRING;
            end
            default: begin
                // sticky error, counters frozen
                scan_mode = MODE_ERROR;
            end
        endcase

        if (eot) begin
            // flush whatever is still open, then the end-of-file token
            if (scan_mode == MODE_IDENT || scan_mode == MODE_NUMBER) begin
                emit_word();
            end else if (scan_mode == MODE_STRING || scan_mode == MODE_ESCAPE) begin
                emit(CLS_ERROR, tok_lead, tok_line, tok_col, tok_len, FAULT_UNTERM);
            end else if (scan_mode == MODE_SLASH) begin
                emit(CLS_ERROR, CH_SLASH, tok_line, tok_col, LEN_W'(1), FAULT_SLASH);
            end
            emit(CLS_EOF, CH_NUL, cur_line, cur_col, '0, FAULT_NONE);
            clear_scan();
        end

        if (expected_tokens.size() > base_count) begin
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // File building
    // ------------------------------------------------------------------
    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) file_buf.push_back(s[i]);
    endtask

    // Moves the file under construction into the request queue,
    // with the end-of-file mark on its final byte
    task automatic push_file(bit steady);
        t_src_byte item;
        while (file_buf.size() > 0) begin
            item.ch     = file_buf.pop_front();
            item.eot    = file_buf.size() == 0;
            item.steady = steady;
            pending_bytes.push_back(item);
            total_bytes++;
        end
    endtask

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 1) == 0) return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // Printable string body byte, never a quote or a backslash
    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        c = 8'($urandom_range(32, 126));
        if (c == CH_QUOTE || c == CH_BSLASH) c = "x";
        return c;
    endfunction

    // Mostly well-formed token runs, with a little breakage and noise
    task automatic compose_random_file();
        int         parts;
        logic [7:0] c;
        parts = $urandom_range(2, 10);
        repeat (parts) begin
            case ($urandom_range(0, 11))
                0: begin
                    case ($urandom_range(0, 4))
                        0: file_buf.push_back(CH_LBRACE);
                        1: file_buf.push_back(CH_RBRACE);
                        2: file_buf.push_back(CH_COLON);
                        3: file_buf.push_back(CH_COMMA);
                        default: file_buf.push_back(CH_AT);
                    endcase
                end
                1, 2: begin
                    case ($urandom_range(0, 3))
                        0: file_buf.push_back(CH_UNDER);
                        1: file_buf.push_back(CH_DOLLAR);
                        default: file_buf.push_back(pick_letter());
                    endcase
                    repeat ($urandom_range(0, 5)) begin
                        case ($urandom_range(0, 2))
                            0: file_buf.push_back(CH_UNDER);
                            1: file_buf.push_back(pick_digit());
                            default: file_buf.push_back(pick_letter());
                        endcase
                    end
                end
                3, 4: begin
                    case ($urandom_range(0, 4))
                        0: file_buf.push_back(CH_PLUS);
                        1: file_buf.push_back(CH_MINUS);
                        2: file_buf.push_back(CH_DOT);
                        default: file_buf.push_back(pick_digit());
                    endcase
                    repeat ($urandom_range(0, 5)) begin
                        if ($urandom_range(0, 3) == 0) file_buf.push_back(CH_DOT);
                        else file_buf.push_back(pick_digit());
                    end
                end
                5, 6: begin
                    file_buf.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 6)) begin
                        if ($urandom_range(0, 5) == 0) begin
                            // escaped byte may be anything, line ends included
                            file_buf.push_back(CH_BSLASH);
                            file_buf.push_back(8'($urandom_range(0, 255)));
                        end else begin
                            file_buf.push_back(pick_plain());
                        end
                    end
                    file_buf.push_back(CH_QUOTE);
                end
                7: begin
                    if ($urandom_range(0, 1) == 0) file_buf.push_back(CH_SPACE);
                    else file_buf.push_back(CH_TAB);
                end
                8: begin
                    case ($urandom_range(0, 2))
                        0: file_buf.push_back(CH_CR);
                        1: file_buf.push_back(CH_LF);
                        default: begin
                            file_buf.push_back(CH_CR);
                            file_buf.push_back(CH_LF);
                        end
                    endcase
                end
                9: begin
                    put_text("//");
                    repeat ($urandom_range(0, 6)) begin
                        c = 8'($urandom_range(0, 255));
                        if (c == CH_CR || c == CH_LF) c = CH_SPACE;
                        file_buf.push_back(c);
                    end
                    if ($urandom_range(0, 1) == 0) file_buf.push_back(CH_LF);
                    else file_buf.push_back(CH_CR);
                end
                10: begin
                    if ($urandom_range(0, 1) == 0) begin
                        // string cut by a bare line end
                        file_buf.push_back(CH_QUOTE);
                        repeat ($urandom_range(0, 3)) file_buf.push_back(pick_plain());
                        if ($urandom_range(0, 1) == 0) file_buf.push_back(CH_CR);
                        else file_buf.push_back(CH_LF);
                    end else begin
                        file_buf.push_back(CH_SLASH);
                        c = pick_plain();
                        if (c == CH_SLASH) c = "y";
                        file_buf.push_back(c);
                    end
                end
                default: begin
                    file_buf.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            if ($urandom_range(0, 2) == 0) file_buf.push_back(CH_SPACE);
        end
    endtask

    // ------------------------------------------------------------------
    // Byte driver: one request at a time from the pending queue,
    // changing only at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk) begin : byte_driver
        t_src_byte item;
        logic      drive;
        if (rst_n) begin
            drive = byte_ch.valid;
            if (byte_ch.valid && bytes_taken != bytes_seen) begin
                // request taken at the last rising edge
                bytes_seen = bytes_taken;
                drive      = 1'b0;
            end
            if (!drive) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_bytes.size() > 0) begin
                    item = pending_bytes.pop_front();
                    byte_ch.char_byte   <= item.ch;
                    byte_ch.end_of_text <= item.eot;
                    drive    = 1'b1;
                    gap_left = item.steady ? 0 : $urandom_range(0, STALL_MAX);
                end
            end
            byte_ch.valid <= drive;
        end
    end

    // ------------------------------------------------------------------
    // Token receiver: random stall after each token, with the odd
    // stretch of back-to-back acceptance
    // ------------------------------------------------------------------
    always @(negedge clk) begin : token_receiver
        if (rst_n) begin
            if (tokens_taken != tokens_seen) begin
                tokens_seen = tokens_taken;
                if (steady_tokens > 0) begin
                    steady_tokens--;
                end else begin
                    stall_left = $urandom_range(0, STALL_MAX);
                    if ($urandom_range(0, 15) == 0) steady_tokens = 20;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                token_ch.ready <= 1'b0;
            end else begin
                token_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted byte, checks every accepted token
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_result want;
        if (rst_n) begin
            if (byte_ch.valid && byte_ch.ready) begin
                tokenize_byte(byte_ch.char_byte, byte_ch.end_of_text);
                bytes_taken++;
            end
            if (token_ch.valid && token_ch.ready) begin
                tokens_taken++;
                if (expected_tokens.size() == 0) begin
                    note_error($sformatf("token %0d arrived with nothing expected", tokens_taken));
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("class",  32'(token_ch.token_class),  32'(want.cls));
                    check_field("lead",   32'(token_ch.lead_byte),    32'(want.lead));
                    check_field("line",   32'(token_ch.start_line),   32'(want.line));
                    check_field("column", 32'(token_ch.start_column), 32'(want.col));
                    check_field("length", 32'(token_ch.token_length), 32'(want.len));
                    check_field("fault",  32'(token_ch.fault_code),   32'(want.fault));
                    check_field("last",   32'(token_ch.run_last),     32'(want.last));
                end
            end
        end
    end

    // Watchdog: too long without any request moving on either channel
    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((byte_ch.valid && byte_ch.ready) || (token_ch.valid && token_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int random_base;

        rst_n                = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.char_byte    = '0;
        byte_ch.end_of_text  = 1'b0;
        token_ch.ready       = 1'b0;
        clear_scan();

        // Directed: all symbols, ident from '_' and '$', number from '-',
        // escaped quote in a string, comment, CRLF, bare CR, number open at end of file
        put_text("{}:,@_Z9 -.5");
        file_buf.push_back(CH_TAB);
        put_text("\"\\\"\"//x");
        file_buf.push_back(CH_CR);
        file_buf.push_back(CH_LF);
        put_text("$");
        file_buf.push_back(CH_CR);
        put_text("5");
        push_file(0);
        // lone slash followed by another byte
        put_text("/x");
        push_file(0);
        // string cut by LF
        put_text("\"a");
        file_buf.push_back(CH_LF);
        push_file(0);
        // number ended by an invalid byte of all ones
        put_text("+");
        file_buf.push_back(8'hFF);
        push_file(0);
        // ident ended by a slash that is the final byte
        put_text("a/");
        push_file(0);
        // end of file straight after a backslash inside a string
        put_text("\"\\");
        push_file(0);
        // single invalid zero byte carrying the end mark
        file_buf.push_back(CH_NUL);
        push_file(0);

        // Random files, some sent back to back
        random_base = total_bytes;
        while (total_bytes - random_base < RANDOM_BYTES) begin
            compose_random_file();
            push_file($urandom_range(0, 3) == 0);
        end

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        while (bytes_taken != total_bytes || expected_tokens.size() > 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
